// ----- rtl/acf_pkg.sv -----
`timescale 1ns / 1ps

package acf_pkg;

  // Fixed widths of the arithmetic
  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  localparam int SQRT_STEPS   = 30;
  localparam int CW           = 52;   // CORDIC x and y
  localparam int ZW           = 34;   // angles, sines and cosines
  localparam int MW           = 34;   // multiplier operands
  localparam int AW           = 64;   // accumulator
  localparam int PCW          = 6;    // sequence counter
  localparam int ITW          = 5;    // iteration counter

  // Iteration counter values of the last square root and CORDIC passes
  localparam logic [ITW-1:0] SQRT_LAST   = ITW'(SQRT_STEPS - 1);
  localparam logic [ITW-1:0] CORDIC_LAST = ITW'(CORDIC_N - 1);

  localparam logic signed [ZW-1:0] ANG_PI      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [ZW-1:0] GAIN_INV    = 34'sd652032874;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
  } acf_in_t;

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic signed [15:0] yaw_angle;
  } acf_out_t;

  typedef enum logic [0:0] {
    CFG_TIME_STEP,
    CFG_BLEND_WEIGHT
  } cfg_idx_t;

  typedef enum logic [4:0] {
    MUL_NONE, MUL_AXAX, MUL_AZAZ, MUL_MXCP, MUL_MZSP, MUL_SRSP, MUL_SRCP,
    MUL_MXT1, MUL_MYCR, MUL_MZT2, MUL_GX, MUL_GY, MUL_GZ,
    MUL_AP, MUL_AR, MUL_AY, MUL_BP, MUL_BR, MUL_BY
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_LOAD4
  } acc_op_t;

  typedef enum logic [4:0] {
    ST_NONE, ST_SQRT_INIT, ST_VEC_P, ST_VEC_R, ST_VEC_Y, ST_ROT_P, ST_ROT_R,
    ST_PREF, ST_RREF, ST_YREF, ST_SCP, ST_SCR, ST_XH, ST_YH, ST_T1, ST_T2,
    ST_PINT, ST_RINT, ST_YINT, ST_OP, ST_OR, ST_OY
  } st_op_t;

  typedef enum logic [1:0] {
    IT_NONE, IT_SQRT, IT_CORDIC
  } iter_t;

  typedef enum logic [1:0] {
    S_IDLE, S_RUN, S_ITER, S_OUT
  } state_t;

  // One entry of the sequence program
  typedef struct packed {
    mul_sel_t mul;
    acc_op_t  acc;
    st_op_t   st;
    iter_t    iter;
    logic     last;
  } prog_t;

  // Command word from the controller to the datapath
  typedef struct packed {
    mul_sel_t         mul;
    acc_op_t          acc;
    st_op_t           st;
    iter_t            step;
    logic [ITW-1:0]   idx;
    logic             ld_in;
    logic             ld_out;
  } dp_cmd_t;

  // Arctangent of 2^-i with 30 fractional bits, truncated
  function automatic logic signed [ZW-1:0] atan_tab(input logic [ITW-1:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:    v = 34'sh3243F6A8;
      5'd1:    v = 34'sh1DAC6705;
      5'd2:    v = 34'sh0FADBAFC;
      5'd3:    v = 34'sh07F56EA6;
      5'd4:    v = 34'sh03FEAB76;
      5'd5:    v = 34'sh01FFD55B;
      5'd6:    v = 34'sh00FFFAAA;
      5'd7:    v = 34'sh007FFF55;
      5'd8:    v = 34'sh003FFFEA;
      5'd9:    v = 34'sh001FFFFD;
      5'd10:   v = 34'sh000FFFFF;
      5'd11:   v = 34'sh0007FFFF;
      5'd12:   v = 34'sh0003FFFF;
      5'd13:   v = 34'sh0001FFFF;
      5'd14:   v = 34'sh0000FFFF;
      5'd15:   v = 34'sh00007FFF;
      5'd16:   v = 34'sh00003FFF;
      5'd17:   v = 34'sh00001FFF;
      5'd18:   v = 34'sh00000FFF;
      5'd19:   v = 34'sh000007FF;
      5'd20:   v = 34'sh000003FF;
      5'd21:   v = 34'sh000001FF;
      5'd22:   v = 34'sh000000FF;
      5'd23:   v = 34'sh0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic prog_t mk(input mul_sel_t m, input acc_op_t a, input st_op_t s,
                               input iter_t it, input logic l);
    prog_t p;
    p.mul  = m;
    p.acc  = a;
    p.st   = s;
    p.iter = it;
    p.last = l;
    return p;
  endfunction

  // Sequence of datapath operations for one sample. A product issued in one
  // entry is taken by the accumulator in the next one.
  function automatic prog_t prog(input logic [PCW-1:0] pc);
    prog_t p;
    unique case (pc)
      6'd0:    p = mk(MUL_AXAX, ACC_NONE,  ST_NONE,      IT_NONE,   1'b0);
      6'd1:    p = mk(MUL_AZAZ, ACC_LOAD,  ST_NONE,      IT_NONE,   1'b0);
      6'd2:    p = mk(MUL_NONE, ACC_ADD,   ST_NONE,      IT_NONE,   1'b0);
      6'd3:    p = mk(MUL_NONE, ACC_NONE,  ST_SQRT_INIT, IT_SQRT,   1'b0);
      6'd4:    p = mk(MUL_NONE, ACC_NONE,  ST_VEC_P,     IT_CORDIC, 1'b0);
      6'd5:    p = mk(MUL_NONE, ACC_NONE,  ST_PREF,      IT_NONE,   1'b0);
      6'd6:    p = mk(MUL_NONE, ACC_NONE,  ST_VEC_R,     IT_CORDIC, 1'b0);
      6'd7:    p = mk(MUL_NONE, ACC_NONE,  ST_RREF,      IT_NONE,   1'b0);
      6'd8:    p = mk(MUL_NONE, ACC_NONE,  ST_ROT_P,     IT_CORDIC, 1'b0);
      6'd9:    p = mk(MUL_NONE, ACC_NONE,  ST_SCP,       IT_NONE,   1'b0);
      6'd10:   p = mk(MUL_NONE, ACC_NONE,  ST_ROT_R,     IT_CORDIC, 1'b0);
      6'd11:   p = mk(MUL_NONE, ACC_NONE,  ST_SCR,       IT_NONE,   1'b0);
      6'd12:   p = mk(MUL_MXCP, ACC_NONE,  ST_NONE,      IT_NONE,   1'b0);
      6'd13:   p = mk(MUL_MZSP, ACC_LOAD,  ST_NONE,      IT_NONE,   1'b0);
      6'd14:   p = mk(MUL_NONE, ACC_ADD,   ST_NONE,      IT_NONE,   1'b0);
      6'd15:   p = mk(MUL_SRSP, ACC_NONE,  ST_XH,        IT_NONE,   1'b0);
      6'd16:   p = mk(MUL_NONE, ACC_LOAD,  ST_NONE,      IT_NONE,   1'b0);
      6'd17:   p = mk(MUL_SRCP, ACC_NONE,  ST_T1,        IT_NONE,   1'b0);
      6'd18:   p = mk(MUL_NONE, ACC_LOAD,  ST_NONE,      IT_NONE,   1'b0);
      6'd19:   p = mk(MUL_MXT1, ACC_NONE,  ST_T2,        IT_NONE,   1'b0);
      6'd20:   p = mk(MUL_MYCR, ACC_LOAD,  ST_NONE,      IT_NONE,   1'b0);
      6'd21:   p = mk(MUL_MZT2, ACC_ADD,   ST_NONE,      IT_NONE,   1'b0);
      6'd22:   p = mk(MUL_NONE, ACC_SUB,   ST_NONE,      IT_NONE,   1'b0);
      6'd23:   p = mk(MUL_NONE, ACC_NONE,  ST_YH,        IT_NONE,   1'b0);
      6'd24:   p = mk(MUL_NONE, ACC_NONE,  ST_VEC_Y,     IT_CORDIC, 1'b0);
      6'd25:   p = mk(MUL_GX,   ACC_NONE,  ST_YREF,      IT_NONE,   1'b0);
      6'd26:   p = mk(MUL_GY,   ACC_LOAD,  ST_NONE,      IT_NONE,   1'b0);
      6'd27:   p = mk(MUL_GZ,   ACC_LOAD,  ST_PINT,      IT_NONE,   1'b0);
      6'd28:   p = mk(MUL_NONE, ACC_LOAD,  ST_RINT,      IT_NONE,   1'b0);
      6'd29:   p = mk(MUL_AP,   ACC_NONE,  ST_YINT,      IT_NONE,   1'b0);
      6'd30:   p = mk(MUL_BP,   ACC_LOAD4, ST_NONE,      IT_NONE,   1'b0);
      6'd31:   p = mk(MUL_AR,   ACC_ADD,   ST_NONE,      IT_NONE,   1'b0);
      6'd32:   p = mk(MUL_BR,   ACC_LOAD4, ST_OP,        IT_NONE,   1'b0);
      6'd33:   p = mk(MUL_AY,   ACC_ADD,   ST_NONE,      IT_NONE,   1'b0);
      6'd34:   p = mk(MUL_BY,   ACC_LOAD4, ST_OR,        IT_NONE,   1'b0);
      6'd35:   p = mk(MUL_NONE, ACC_ADD,   ST_NONE,      IT_NONE,   1'b0);
      6'd36:   p = mk(MUL_NONE, ACC_NONE,  ST_OY,        IT_NONE,   1'b1);
      default: p = mk(MUL_NONE, ACC_NONE,  ST_NONE,      IT_NONE,   1'b1);
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/attitude_complementary_filter.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Word
// in_       input      in_valid / in_stall  acf_in_t: accelerometer, gyro, magnetometer
// out_      output     out_valid/out_stall  acf_out_t: pitch, roll, yaw angles
// cfg_      input      cfg_we               index 0 time step, index 1 blend weight
//
// A sample runs from its acceptance to its result through the 30-step square root, the five
// CORDIC passes and the 37-entry sequence around one shared multiplier; the controller passes
// through its idle state before it accepts the next sample.
// Synchronous active-low reset restores the configuration and clears the integrators.
// A finished word waits in the output register while the next sample is taken;
// the sample after that waits only if the output stays stalled.

module attitude_complementary_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  acf_pkg::acf_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output acf_pkg::acf_out_t  out_data,
  input  logic               cfg_we,
  input  acf_pkg::cfg_idx_t  cfg_index,
  input  logic [15:0]        cfg_data
);

  acf_pkg::dp_cmd_t cmd;

  acf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  acf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ----- rtl/acf_ctrl.sv -----
`timescale 1ns / 1ps

module acf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output acf_pkg::dp_cmd_t  cmd
);

  acf_pkg::state_t                state_r, state_nxt;
  logic [acf_pkg::PCW-1:0]        pc_r, pc_nxt;
  logic [acf_pkg::ITW-1:0]        it_r, it_nxt;
  acf_pkg::iter_t                 mode_r, mode_nxt;
  logic                           ov_r, ov_nxt;
  acf_pkg::prog_t                 op;
  logic                           it_last;

  assign op        = acf_pkg::prog(pc_r);
  assign out_valid = ov_r;
  assign in_stall  = (state_r != acf_pkg::S_IDLE);

  // Last pass of the running iteration
  always_comb begin
    unique case (mode_r)
      acf_pkg::IT_SQRT:   it_last = (it_r == acf_pkg::SQRT_LAST);
      acf_pkg::IT_CORDIC: it_last = (it_r == acf_pkg::CORDIC_LAST);
      default:            it_last = 1'b1;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acf_pkg::S_IDLE;
      pc_r    <= '0;
      it_r    <= '0;
      mode_r  <= acf_pkg::IT_NONE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      it_r    <= it_nxt;
      mode_r  <= mode_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt  = state_r;
    pc_nxt     = pc_r;
    it_nxt     = it_r;
    mode_nxt   = mode_r;
    ov_nxt     = ov_r && out_stall;
    cmd.mul    = acf_pkg::MUL_NONE;
    cmd.acc    = acf_pkg::ACC_NONE;
    cmd.st     = acf_pkg::ST_NONE;
    cmd.step   = acf_pkg::IT_NONE;
    cmd.idx    = it_r;
    cmd.ld_in  = 1'b0;
    cmd.ld_out = 1'b0;
    unique case (state_r)
      acf_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          pc_nxt    = '0;
          state_nxt = acf_pkg::S_RUN;
        end
      end
      acf_pkg::S_RUN: begin
        cmd.mul = op.mul;
        cmd.acc = op.acc;
        cmd.st  = op.st;
        if (op.last) begin
          state_nxt = acf_pkg::S_OUT;
        end else if (op.iter != acf_pkg::IT_NONE) begin
          mode_nxt  = op.iter;
          it_nxt    = '0;
          state_nxt = acf_pkg::S_ITER;
        end else begin
          pc_nxt = pc_r + 1'b1;
        end
      end
      acf_pkg::S_ITER: begin
        cmd.step = mode_r;
        it_nxt   = it_r + 1'b1;
        if (it_last) begin
          pc_nxt    = pc_r + 1'b1;
          state_nxt = acf_pkg::S_RUN;
        end
      end
      acf_pkg::S_OUT: begin
        if (!ov_r || !out_stall) begin
          cmd.ld_out = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = acf_pkg::S_IDLE;
        end
      end
      default: state_nxt = acf_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- rtl/acf_dp.sv -----
`timescale 1ns / 1ps

module acf_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  acf_pkg::dp_cmd_t   cmd,
  input  acf_pkg::acf_in_t   in_data,
  output acf_pkg::acf_out_t  out_data,
  input  logic               cfg_we,
  input  acf_pkg::cfg_idx_t  cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int CW = acf_pkg::CW;
  localparam int ZW = acf_pkg::ZW;
  localparam int MW = acf_pkg::MW;
  localparam int AW = acf_pkg::AW;

  acf_pkg::acf_in_t         smp_r, smp_nxt;
  acf_pkg::acf_out_t        res_r, res_nxt;
  acf_pkg::acf_out_t        out_r, out_nxt;
  logic [15:0]              ts_r, ts_nxt;
  logic [15:0]              alpha_r, alpha_nxt;
  logic signed [AW-1:0]     p_r, p_nxt;
  logic signed [AW-1:0]     acc_r, acc_nxt;
  logic [59:0]              rad_r, rad_nxt;
  logic [31:0]              rem_r, rem_nxt;
  logic [29:0]              root_r, root_nxt;
  logic signed [CW-1:0]     cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [ZW-1:0]     cz_r, cz_nxt, off_r, off_nxt;
  logic                     zero_r, zero_nxt, neg_r, neg_nxt, vec_r, vec_nxt;
  logic signed [ZW-1:0]     pref_r, pref_nxt, rref_r, rref_nxt, yref_r, yref_nxt;
  logic signed [ZW-1:0]     sp_r, sp_nxt, cp_r, cp_nxt, sr_r, sr_nxt, cr_r, cr_nxt;
  logic signed [ZW-1:0]     t1_r, t1_nxt, t2_r, t2_nxt;
  logic signed [CW-1:0]     xh_r, xh_nxt, yh_r, yh_nxt;
  logic signed [31:0]       pint_r, pint_nxt, rint_r, rint_nxt, yint_r, yint_nxt;

  // Multiplier operands
  logic signed [MW-1:0]     ma, mb;
  logic signed [2*MW-1:0]   prod;
  logic signed [MW-1:0]     alpha_s, beta_s, ts_s;

  // Shared CORDIC step
  logic signed [CW-1:0]     dx, dy;
  logic signed [ZW-1:0]     tab;
  logic                     up;

  // Square root digit step
  logic [33:0]              rem2;
  logic [31:0]              trial;
  logic                     ge;

  // Vectoring and rotation start values
  logic signed [CW-1:0]     vx, vy;
  logic signed [ZW-1:0]     ang;

  // Rounding, saturation and integration
  logic signed [AW-1:0]     rnd;
  logic signed [15:0]       blend_sat;
  logic signed [33:0]       isum;
  logic signed [31:0]       isat;
  logic signed [31:0]       iin;

  assign out_data = out_r;
  assign alpha_s  = $signed({18'd0, alpha_r});
  assign beta_s   = $signed({17'd0, 17'h10000 - {1'b0, alpha_r}});
  assign ts_s     = $signed({18'd0, ts_r});

  // Operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.mul)
      acf_pkg::MUL_AXAX: begin ma = MW'(smp_r.accel_x); mb = MW'(smp_r.accel_x); end
      acf_pkg::MUL_AZAZ: begin ma = MW'(smp_r.accel_z); mb = MW'(smp_r.accel_z); end
      acf_pkg::MUL_MXCP: begin ma = MW'(smp_r.mag_x);   mb = cp_r; end
      acf_pkg::MUL_MZSP: begin ma = MW'(smp_r.mag_z);   mb = sp_r; end
      acf_pkg::MUL_SRSP: begin ma = sr_r;               mb = sp_r; end
      acf_pkg::MUL_SRCP: begin ma = sr_r;               mb = cp_r; end
      acf_pkg::MUL_MXT1: begin ma = MW'(smp_r.mag_x);   mb = t1_r; end
      acf_pkg::MUL_MYCR: begin ma = MW'(smp_r.mag_y);   mb = cr_r; end
      acf_pkg::MUL_MZT2: begin ma = MW'(smp_r.mag_z);   mb = t2_r; end
      acf_pkg::MUL_GX:   begin ma = MW'(smp_r.gyro_x);  mb = ts_s; end
      acf_pkg::MUL_GY:   begin ma = MW'(smp_r.gyro_y);  mb = ts_s; end
      acf_pkg::MUL_GZ:   begin ma = MW'(smp_r.gyro_z);  mb = ts_s; end
      acf_pkg::MUL_AP:   begin ma = alpha_s;            mb = MW'(pint_r); end
      acf_pkg::MUL_AR:   begin ma = alpha_s;            mb = MW'(rint_r); end
      acf_pkg::MUL_AY:   begin ma = alpha_s;            mb = MW'(yint_r); end
      acf_pkg::MUL_BP:   begin ma = beta_s;             mb = pref_r; end
      acf_pkg::MUL_BR:   begin ma = beta_s;             mb = rref_r; end
      acf_pkg::MUL_BY:   begin ma = beta_s;             mb = yref_r; end
      default:           begin ma = '0;                 mb = '0; end
    endcase
  end

  assign prod = ma * mb;

  // CORDIC step: vectoring drives y to zero, rotation drives z to zero
  assign dx  = cy_r >>> cmd.idx;
  assign dy  = cx_r >>> cmd.idx;
  assign tab = acf_pkg::atan_tab(cmd.idx);
  assign up  = vec_r ? ~cy_r[CW-1] : cz_r[ZW-1];

  // One root bit per step, two radicand bits in
  assign rem2  = {rem_r, rad_r[59:58]};
  assign trial = {root_r, 2'b01};
  assign ge    = (rem2 >= {2'b00, trial});

  // Vector operands for the three arctangents
  always_comb begin
    unique case (cmd.st)
      acf_pkg::ST_VEC_P: begin
        vx = $signed({22'd0, root_r});
        vy = CW'(smp_r.accel_y) <<< 14;
      end
      acf_pkg::ST_VEC_R: begin
        vx = CW'(smp_r.accel_z) <<< 14;
        vy = -(CW'(smp_r.accel_x) <<< 14);
      end
      default: begin
        vx = xh_r;
        vy = -yh_r;
      end
    endcase
  end

  assign ang = (cmd.st == acf_pkg::ST_ROT_P) ? pref_r : rref_r;

  // Blend rounding half up to Q3.13, then clamp to 16 bits
  assign rnd = (acc_r + (AW'(1) <<< 32)) >>> 33;
  always_comb begin
    if (rnd > AW'(32767)) begin
      blend_sat = 16'sh7FFF;
    end else if (rnd < -AW'(32768)) begin
      blend_sat = -16'sh8000;
    end else begin
      blend_sat = rnd[15:0];
    end
  end

  // Integrator add with clamp
  always_comb begin
    unique case (cmd.st)
      acf_pkg::ST_PINT: iin = pint_r;
      acf_pkg::ST_RINT: iin = rint_r;
      default:          iin = yint_r;
    endcase
  end
  assign isum = 34'(iin) + acc_r[33:0];
  always_comb begin
    if (isum > 34'sh07FFFFFFF) begin
      isat = 32'sh7FFFFFFF;
    end else if (isum < -34'sh080000000) begin
      isat = -32'sh80000000;
    end else begin
      isat = isum[31:0];
    end
  end

  // Next values of the datapath registers
  always_comb begin
    smp_nxt   = smp_r;
    res_nxt   = res_r;
    out_nxt   = out_r;
    ts_nxt    = ts_r;
    alpha_nxt = alpha_r;
    p_nxt     = p_r;
    acc_nxt   = acc_r;
    rad_nxt   = rad_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    cz_nxt    = cz_r;
    off_nxt   = off_r;
    zero_nxt  = zero_r;
    neg_nxt   = neg_r;
    vec_nxt   = vec_r;
    pref_nxt  = pref_r;
    rref_nxt  = rref_r;
    yref_nxt  = yref_r;
    sp_nxt    = sp_r;
    cp_nxt    = cp_r;
    sr_nxt    = sr_r;
    cr_nxt    = cr_r;
    t1_nxt    = t1_r;
    t2_nxt    = t2_r;
    xh_nxt    = xh_r;
    yh_nxt    = yh_r;
    pint_nxt  = pint_r;
    rint_nxt  = rint_r;
    yint_nxt  = yint_r;

    // Configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        acf_pkg::CFG_TIME_STEP:    ts_nxt    = cfg_data;
        acf_pkg::CFG_BLEND_WEIGHT: alpha_nxt = cfg_data;
        default:                   ts_nxt    = ts_r;
      endcase
    end

    if (cmd.ld_in) begin
      smp_nxt = in_data;
    end
    if (cmd.ld_out) begin
      out_nxt = res_r;
    end

    // Product register
    if (cmd.mul != acf_pkg::MUL_NONE) begin
      p_nxt = prod[AW-1:0];
    end

    // Accumulator
    unique case (cmd.acc)
      acf_pkg::ACC_LOAD:  acc_nxt = p_r;
      acf_pkg::ACC_ADD:   acc_nxt = acc_r + p_r;
      acf_pkg::ACC_SUB:   acc_nxt = acc_r - p_r;
      acf_pkg::ACC_LOAD4: acc_nxt = p_r <<< 2;
      default:            acc_nxt = acc_r;
    endcase

    // Stores and starts of the iterative units
    unique case (cmd.st)
      acf_pkg::ST_SQRT_INIT: begin
        rad_nxt  = {acc_r[31:0], 28'd0};
        rem_nxt  = '0;
        root_nxt = '0;
      end
      acf_pkg::ST_VEC_P, acf_pkg::ST_VEC_R, acf_pkg::ST_VEC_Y: begin
        vec_nxt  = 1'b1;
        cz_nxt   = '0;
        zero_nxt = (vx == '0) && (vy == '0);
        if (vx[CW-1]) begin
          off_nxt = vy[CW-1] ? -acf_pkg::ANG_PI : acf_pkg::ANG_PI;
          cx_nxt  = -vx;
          cy_nxt  = -vy;
        end else begin
          off_nxt = '0;
          cx_nxt  = vx;
          cy_nxt  = vy;
        end
      end
      acf_pkg::ST_ROT_P, acf_pkg::ST_ROT_R: begin
        vec_nxt = 1'b0;
        cx_nxt  = CW'(acf_pkg::GAIN_INV);
        cy_nxt  = '0;
        if (ang > acf_pkg::ANG_HALF_PI) begin
          cz_nxt  = ang - acf_pkg::ANG_PI;
          neg_nxt = 1'b1;
        end else if (ang < -acf_pkg::ANG_HALF_PI) begin
          cz_nxt  = ang + acf_pkg::ANG_PI;
          neg_nxt = 1'b1;
        end else begin
          cz_nxt  = ang;
          neg_nxt = 1'b0;
        end
      end
      acf_pkg::ST_PREF: pref_nxt = zero_r ? '0 : cz_r + off_r;
      acf_pkg::ST_RREF: rref_nxt = zero_r ? '0 : cz_r + off_r;
      acf_pkg::ST_YREF: yref_nxt = zero_r ? '0 : cz_r + off_r;
      acf_pkg::ST_SCP: begin
        sp_nxt = neg_r ? -cy_r[ZW-1:0] : cy_r[ZW-1:0];
        cp_nxt = neg_r ? -cx_r[ZW-1:0] : cx_r[ZW-1:0];
      end
      acf_pkg::ST_SCR: begin
        sr_nxt = neg_r ? -cy_r[ZW-1:0] : cy_r[ZW-1:0];
        cr_nxt = neg_r ? -cx_r[ZW-1:0] : cx_r[ZW-1:0];
      end
      acf_pkg::ST_XH:   xh_nxt   = acc_r[CW-1:0];
      acf_pkg::ST_YH:   yh_nxt   = acc_r[CW-1:0];
      acf_pkg::ST_T1:   t1_nxt   = acc_r[AW-1:30];
      acf_pkg::ST_T2:   t2_nxt   = acc_r[AW-1:30];
      acf_pkg::ST_PINT: pint_nxt = isat;
      acf_pkg::ST_RINT: rint_nxt = isat;
      acf_pkg::ST_YINT: yint_nxt = isat;
      acf_pkg::ST_OP:   res_nxt.pitch_angle = blend_sat;
      acf_pkg::ST_OR:   res_nxt.roll_angle  = blend_sat;
      acf_pkg::ST_OY:   res_nxt.yaw_angle   = blend_sat;
      default:          res_nxt = res_r;
    endcase

    // Iteration steps
    unique case (cmd.step)
      acf_pkg::IT_SQRT: begin
        rad_nxt = {rad_r[57:0], 2'b00};
        if (ge) begin
          rem_nxt  = 32'(rem2 - {2'b00, trial});
          root_nxt = {root_r[28:0], 1'b1};
        end else begin
          rem_nxt  = rem2[31:0];
          root_nxt = {root_r[28:0], 1'b0};
        end
      end
      acf_pkg::IT_CORDIC: begin
        if (up) begin
          cx_nxt = cx_r + dx;
          cy_nxt = cy_r - dy;
          cz_nxt = cz_r + tab;
        end else begin
          cx_nxt = cx_r - dx;
          cy_nxt = cy_r + dy;
          cz_nxt = cz_r - tab;
        end
      end
      default: cz_nxt = cz_nxt;
    endcase
  end

  // Configuration and integrators reset; working registers do not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r    <= 16'd655;
      alpha_r <= 16'd64225;
      pint_r  <= '0;
      rint_r  <= '0;
      yint_r  <= '0;
    end else begin
      ts_r    <= ts_nxt;
      alpha_r <= alpha_nxt;
      pint_r  <= pint_nxt;
      rint_r  <= rint_nxt;
      yint_r  <= yint_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r  <= smp_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    p_r    <= p_nxt;
    acc_r  <= acc_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    cz_r   <= cz_nxt;
    off_r  <= off_nxt;
    zero_r <= zero_nxt;
    neg_r  <= neg_nxt;
    vec_r  <= vec_nxt;
    pref_r <= pref_nxt;
    rref_r <= rref_nxt;
    yref_r <= yref_nxt;
    sp_r   <= sp_nxt;
    cp_r   <= cp_nxt;
    sr_r   <= sr_nxt;
    cr_r   <= cr_nxt;
    t1_r   <= t1_nxt;
    t2_r   <= t2_nxt;
    xh_r   <= xh_nxt;
    yh_r   <= yh_nxt;
  end

endmodule

// ----- tb/attitude_complementary_filter_tb.sv -----
`timescale 1ns / 1ps

module attitude_complementary_filter_tb;

  localparam int IDLE_LIMIT  = 40000;
  localparam int DRAIN_WAIT  = 200;
  localparam int HOLD_CYCLES = 1500;

  localparam longint ANGLE_STEP [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };
  localparam longint HALF_TURN  = 64'd3373259426;
  localparam longint QUARTER    = 64'd1686629713;
  localparam longint GAIN_START = 64'd652032874;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  acf_pkg::acf_in_t    in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  acf_pkg::acf_out_t   out_data;
  logic                cfg_we = 1'b0;
  acf_pkg::cfg_idx_t   cfg_index = acf_pkg::CFG_TIME_STEP;
  logic [15:0]         cfg_data = '0;

  // Predictor state and configuration copy.
  logic [15:0] step_size;
  logic [15:0] gyro_weight;
  int          pitch_sum;
  int          roll_sum;
  int          yaw_sum;

  acf_pkg::acf_out_t angles_due[$];
  int       n_sent;
  int       n_recv;
  int       n_bad;
  int       idle_cycles;
  bit       send_gaps = 1'b1;
  bit       recv_gaps = 1'b1;
  int       hold_req = 0;
  int       hold_seen = 0;
  int       hold_left = 0;

  attitude_complementary_filter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Vectoring rotation: angle of (x, y) with 30 fractional bits.
  function automatic longint vec_angle(input longint y, input longint x);
    longint off;
    longint z;
    longint dx;
    longint dy;
    off = 0;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      off = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < acf_pkg::CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ANGLE_STEP[i];
      end else begin
        x -= dx; y += dy; z -= ANGLE_STEP[i];
      end
    end
    return z + off;
  endfunction

  // Rotation mode: sine and cosine of an angle near [-pi, pi].
  function automatic void rot_sincos(input longint a, output longint s, output longint c);
    bit     flip;
    longint x;
    longint y;
    longint dx;
    longint dy;
    flip = 1'b0;
    x = GAIN_START;
    y = 0;
    if (a > QUARTER) begin
      a -= HALF_TURN; flip = 1'b1;
    end else if (a < -QUARTER) begin
      a += HALF_TURN; flip = 1'b1;
    end
    for (int i = 0; i < acf_pkg::CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= ANGLE_STEP[i];
      end else begin
        x += dx; y -= dy; a += ANGLE_STEP[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint root_floor(input longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic int rate_sum(input int acc, input longint rate);
    longint v;
    v = longint'(acc) + rate * longint'({48'd0, step_size});
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return int'(v);
  endfunction

  function automatic logic signed [15:0] mix_angle(input int integ, input longint ref_ang);
    longint a;
    longint v;
    a = longint'({48'd0, gyro_weight});
    v = (a * longint'(integ) * 4 + (65536 - a) * ref_ang + (64'sd1 << 32)) >>> 33;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Full attitude update for one sample; advances the integrators.
  function automatic acf_pkg::acf_out_t attitude_next(input acf_pkg::acf_in_t s);
    longint ax, ay, az, mx, my, mz;
    longint r, p_ref, r_ref, y_ref, sp, cp, sr, cr, xh, yh;
    acf_pkg::acf_out_t o;
    ax = longint'(s.accel_x); ay = longint'(s.accel_y); az = longint'(s.accel_z);
    mx = longint'(s.mag_x);   my = longint'(s.mag_y);   mz = longint'(s.mag_z);
    r = root_floor(longint'(ax * ax + az * az) << 28);
    p_ref = vec_angle(ay * 16384, r);
    r_ref = vec_angle(-ax * 16384, az * 16384);
    rot_sincos(p_ref, sp, cp);
    rot_sincos(r_ref, sr, cr);
    xh = mx * cp + mz * sp;
    yh = mx * ((sr * sp) >>> 30) + my * cr - mz * ((sr * cp) >>> 30);
    y_ref = vec_angle(-yh, xh);
    pitch_sum = rate_sum(pitch_sum, longint'(s.gyro_x));
    roll_sum  = rate_sum(roll_sum, longint'(s.gyro_y));
    yaw_sum   = rate_sum(yaw_sum, longint'(s.gyro_z));
    o.pitch_angle = mix_angle(pitch_sum, p_ref);
    o.roll_angle  = mix_angle(roll_sum, r_ref);
    o.yaw_angle   = mix_angle(yaw_sum, y_ref);
    return o;
  endfunction

  // Offer one word and wait until it is taken; valid stays high afterward.
  task automatic send_sample(input acf_pkg::acf_in_t s);
    if (send_gaps && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 16);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    angles_due.push_back(attitude_next(s));
    n_sent++;
  endtask

  // Lower valid and wait until every expected word has come back.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (angles_due.size() != 0) @(posedge clk);
  endtask

  // One register write, then write enable is lowered before the task returns, so back-to-back writes stay apart.
  task automatic write_reg(input acf_pkg::cfg_idx_t idx, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == acf_pkg::CFG_TIME_STEP) step_size = v;
    else gyro_weight = v;
    @(posedge clk);
  endtask

  function automatic acf_pkg::acf_in_t any_sample();
    acf_pkg::acf_in_t s;
    s = acf_pkg::acf_in_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    return s;
  endfunction

  // A plausible sample: moderate accelerometer and field, slow rates.
  function automatic acf_pkg::acf_in_t sensor_sample();
    acf_pkg::acf_in_t s;
    s.accel_x = 16'($signed($urandom_range(0, 40000)) - 20000);
    s.accel_y = 16'($signed($urandom_range(0, 40000)) - 20000);
    s.accel_z = 16'($signed($urandom_range(0, 40000)) - 20000);
    s.gyro_x  = 16'($signed($urandom_range(0, 800)) - 400);
    s.gyro_y  = 16'($signed($urandom_range(0, 800)) - 400);
    s.gyro_z  = 16'($signed($urandom_range(0, 800)) - 400);
    s.mag_x   = 16'($signed($urandom_range(0, 6000)) - 3000);
    s.mag_y   = 16'($signed($urandom_range(0, 6000)) - 3000);
    s.mag_z   = 16'($signed($urandom_range(0, 6000)) - 3000);
    return s;
  endfunction

  task automatic test_directed;
    acf_pkg::acf_in_t s;
    s = '0;
    send_sample(s);
    s = {9{16'sh7FFF}};
    send_sample(s);
    s = {9{16'sh8000}};
    send_sample(s);
    // Zero accelerometer with a field present.
    s = '0; s.mag_x = 16'sd1000; s.mag_y = -16'sd2000;
    send_sample(s);
    // Zero compensated field with a tilt.
    s = '0; s.accel_y = 16'sd16384; s.accel_z = 16'sd8000;
    send_sample(s);
    // Negative z and each sign of x for the half-turn offsets.
    s = '0; s.accel_x = 16'sd100; s.accel_z = -16'sd16000;
    s.mag_x = -16'sd3000; s.mag_y = 16'sd1;
    send_sample(s);
    s = '0; s.accel_x = -16'sd100; s.accel_z = -16'sd16000;
    s.mag_x = -16'sd3000; s.mag_y = -16'sd1;
    send_sample(s);
    s = '0; s.accel_x = 16'sh8000; s.accel_z = 16'sd0; s.accel_y = 16'sh8000;
    s.mag_z = 16'sh7FFF;
    send_sample(s);
    drain();
    // Integrator overflow in both directions at the largest step.
    write_reg(acf_pkg::CFG_TIME_STEP, 16'hFFFF);
    s = sensor_sample();
    s.gyro_x = 16'sh7FFF; s.gyro_y = 16'sh8000; s.gyro_z = 16'sh7FFF;
    repeat (3) send_sample(s);
    s.gyro_x = 16'sh8000; s.gyro_y = 16'sh7FFF; s.gyro_z = 16'sh8000;
    repeat (5) send_sample(s);
    drain();
    // Gyro ignored entirely, then reference ignored almost entirely.
    write_reg(acf_pkg::CFG_BLEND_WEIGHT, 16'h0000);
    repeat (3) send_sample(any_sample());
    drain();
    write_reg(acf_pkg::CFG_BLEND_WEIGHT, 16'hFFFF);
    write_reg(acf_pkg::CFG_TIME_STEP, 16'h0000);
    repeat (3) send_sample(any_sample());
    drain();
  endtask

  // Random phases, each with its own register setting.
  task automatic test_random(input int count);
    int k;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(acf_pkg::CFG_TIME_STEP, 16'd655);
          write_reg(acf_pkg::CFG_BLEND_WEIGHT, 16'd64225);
        end
        1: begin
          write_reg(acf_pkg::CFG_TIME_STEP, 16'd0);
          write_reg(acf_pkg::CFG_BLEND_WEIGHT, 16'd0);
        end
        2: begin
          write_reg(acf_pkg::CFG_TIME_STEP, 16'hFFFF);
          write_reg(acf_pkg::CFG_BLEND_WEIGHT, 16'hFFFF);
        end
        default: begin
          write_reg(acf_pkg::CFG_TIME_STEP, 16'($urandom_range(0, 4000)));
          write_reg(acf_pkg::CFG_BLEND_WEIGHT, 16'($urandom));
        end
      endcase
      // The gap-free stretch sits in the middle phase.
      send_gaps = (ph != 3);
      recv_gaps = (ph != 3);
      for (k = 0; k < count / 6; k++) begin
        if ($urandom_range(99) < 75) send_sample(sensor_sample());
        else send_sample(any_sample());
      end
      drain();
    end
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  // Receiver holds off while samples keep coming, so the input stalls.
  task automatic test_backpressure;
    hold_req++;
    repeat (8) send_sample(sensor_sample());
    drain();
  endtask

  initial begin
    step_size   = 16'd655;
    gyro_weight = 16'd64225;
    pitch_sum = 0; roll_sum = 0; yaw_sum = 0;
    n_sent = 0; n_recv = 0; n_bad = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(1000);
    test_backpressure();
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Sent %0d samples and checked %0d attitude words, %0d mismatched,",
             n_sent, n_recv, n_bad);
    $display("over extreme and random settings with gaps, stalls and a long hold-off.");
    if (n_bad == 0 && angles_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= recv_gaps && ($urandom_range(99) < 16);
    end
  end

  // Compare each delivered word with the oldest prediction.
  always @(posedge clk) begin
    acf_pkg::acf_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_recv++;
      if (angles_due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("Unexpected word %h", out_data);
      end else begin
        want = angles_due.pop_front();
        if (want.pitch_angle !== out_data.pitch_angle ||
            want.roll_angle !== out_data.roll_angle ||
            want.yaw_angle !== out_data.yaw_angle) begin
          n_bad++;
          if (n_bad <= 10)
            $display("Word %0d: expected pitch %0d roll %0d yaw %0d, got %0d %0d %0d",
                     n_recv, want.pitch_angle, want.roll_angle, want.yaw_angle,
                     out_data.pitch_angle, out_data.roll_angle, out_data.yaw_angle);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
